@@ rtl/core/cpi_pkg.sv @@
// Shared widths and constants for the cycle ledger / PPS interpolator.
// No dependencies; imported by the divider, the top level and the checker.
`timescale 1ns / 1ps

package cpi_pkg;

  // Raw counter sample and ledger widths
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned LEDGER_W = 64;

  // Nanoseconds per second fits in 30 bits; product and quotient in 62 bits
  localparam int unsigned NS_W     = 30;
  localparam int unsigned PROD_W   = CNT_W + NS_W;
  localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1000000000);

  // Divider step counter
  localparam int unsigned STEP_W   = $clog2(PROD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

  // Reset value of the counter frequency register
  localparam logic [CNT_W-1:0] RESET_CPS = CNT_W'(600000000);

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } seq_state_t;

endpackage

@@ rtl/core/cpi_divider.sv @@
// Restoring divider: PROD_W-bit dividend by CNT_W-bit divisor, one quotient bit per cycle.
// Depends on cpi_pkg.
`timescale 1ns / 1ps

module cpi_divider import cpi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [PROD_W-1:0] quo;

  logic [CNT_W:0]    rem_shift;
  logic              fits;
  logic [CNT_W:0]    rem_diff;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_shift = {rem, quo[PROD_W-1]};
    fits      = (rem_shift >= {1'b0, dvs});
    rem_diff  = rem_shift - {1'b0, dvs};
  end

  // Control: step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/core/cycle_ledger_pps_interpolator.sv @@
// Top level: sample intake, 64-bit ledger, PPS baseline, multiply and divider.
// Depends on cpi_pkg and cpi_divider.
`timescale 1ns / 1ps

// Each accepted sample extends the 64-bit cycle ledger by the wrapped
// difference from the previous sample and, when kind is set, captures the
// sample as the new PPS baseline. The block then returns the ledger and the
// whole nanoseconds since the baseline, floor(elapsed * 10^9 / counter_hz),
// where counter_hz is the counter frequency register written over the
// configuration channel, with a divisor of zero taken as one. Each accepted
// sample goes through these steps in order: the elapsed count is registered,
// it is multiplied by 10^9 in S_MUL, the product is loaded into the divider
// in S_LOAD, the restoring divider works one quotient bit per cycle in S_DIV,
// and S_DONE hands the result to the output register once the output slot is
// free. in_stall is high from S_MUL through S_DONE; a new sample is taken as
// soon as the result sits in the output register, even if it has not been
// collected yet. cfg_ready is always high; write the frequency register only
// while no sample is in flight.
module cycle_ledger_pps_interpolator import cpi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // Configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CNT_W-1:0]    cfg_data,
  // Sample channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [CNT_W-1:0]    counter_value,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LEDGER_W-1:0] cycles_total,
  output logic [PROD_W-1:0]   ns_since_pps
);

  seq_state_t          state;
  seq_state_t          state_next;

  logic [CNT_W-1:0]    counter_hz;
  logic [LEDGER_W-1:0] ledger;
  logic [CNT_W-1:0]    previous_sample;
  logic [CNT_W-1:0]    baseline;
  logic [CNT_W-1:0]    elapsed;
  logic [PROD_W-1:0]   product;

  logic                in_take;
  logic                out_free;
  logic                div_start;
  logic                div_done;
  logic [CNT_W-1:0]    div_divisor;
  logic [PROD_W-1:0]   div_quotient;
  logic [CNT_W-1:0]    sample_diff;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_LOAD);

  assign sample_diff = counter_value - previous_sample;
  assign div_divisor = (counter_hz == '0) ? CNT_W'(1) : counter_hz;

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_take) state_next = S_MUL;
      S_MUL:  state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frequency register
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_hz <= RESET_CPS;
    end else if (cfg_valid && cfg_ready) begin
      counter_hz <= cfg_data;
    end
  end

  // Ledger and previous sample advance on each accepted transaction; baseline only on a PPS sample
  always_ff @(posedge clk) begin
    if (rst) begin
      ledger          <= '0;
      previous_sample <= '0;
      baseline        <= '0;
    end else if (in_take) begin
      ledger          <= ledger + {{(LEDGER_W-CNT_W){1'b0}}, sample_diff};
      previous_sample <= counter_value;
      if (kind) begin
        baseline <= counter_value;
      end
    end
  end

  // Elapsed cycles since baseline; zero on a PPS sample
  always_ff @(posedge clk) begin
    if (in_take) begin
      elapsed <= kind ? '0 : (counter_value - baseline);
    end
  end

  // Scale elapsed cycles to nanosecond units before the divide
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      product <= {{NS_W{1'b0}}, elapsed} * {{CNT_W{1'b0}}, NS_PER_SEC};
    end
  end

  cpi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Output register: load when finished and the slot is free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      cycles_total <= ledger;
      ns_since_pps <= div_quotient;
    end
  end

endmodule

@@ rtl/core/cpi_checker.sv @@
// Port-level checker for the cycle ledger / PPS interpolator, bound to the top level.
// Depends on cpi_pkg and cycle_ledger_pps_interpolator.
`timescale 1ns / 1ps

module cpi_checker import cpi_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [LEDGER_W-1:0] cycles_total,
  input logic [PROD_W-1:0]   ns_since_pps
);

  // Stalled result holds valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cycles_total) && $stable(ns_since_pps))
    else $error("result changed while stalled");

  // An accepted sample makes the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a sample");

  // No result appears the cycle right after a sample is accepted
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A new result only comes out of a busy block
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a sample in flight");

endmodule

bind cycle_ledger_pps_interpolator cpi_checker u_cpi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .cycles_total (cycles_total),
  .ns_since_pps (ns_since_pps)
);
